// ===== rtl/guillotine_rect_packer_unit_assert.svh =====
// Assertion macros used by the checker of the packer.
`ifndef GUILLOTINE_RECT_PACKER_UNIT_ASSERT_SVH
`define GUILLOTINE_RECT_PACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GRP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/grp_pkg.sv =====
// ----------------------------------------------------------------------------
// grp_pkg
// Shared constants, result codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package grp_pkg;

  localparam int MAX_IMAGES_DEF = 256;
  localparam int FREE_DEPTH_DEF = 512;
  localparam int COORD_BITS_DEF = 20;

  localparam int IMG_BITS      = 12;
  localparam int OUT_BITS      = 20;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 80;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_CLEARED = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic    clear;
    logic    load;
    logic    scan_go;
    logic    scan_sq;
    logic    rd_best;
    logic    cap_best;
    logic    rd_last;
    logic    cap_last;
    logic    wr_best;
    logic    wr_bottom;
    logic    commit;
    logic    out_load;
    status_t out_status;
  } grp_cmd_t;

  typedef struct packed {
    logic placed_full;
    logic list_empty;
    logic scan_busy;
    logic found;
    logic best_zero;
    logic cap_fail;
    logic out_free;
  } grp_sts_t;

endpackage

// ===== rtl/guillotine_rect_packer_unit.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer_unit
// Guillotine packer of rectangles into a growing sheet, one word at a time.
//
//   port group | direction | tdata fields (low first)          | tuser
//   in_        | slave     | img_width, img_height             | kind
//   out_       | master    | place_x, place_y, sheet_w, sheet_h | status
//
// A place word runs an area pass over the n live free regions, one region a
// cycle, then a slower squareness pass, both on the single RAM read port;
// the squareness pass is skipped when a region fits without growing the
// sheet. Start and image-limit words skip the scans, and a word with no
// fitting region ends after the area pass. After reset the base region is
// written before the first word is taken. A stalled output holds its word while the next word is worked on.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_unit #(
  parameter int MAX_IMAGES = grp_pkg::MAX_IMAGES_DEF,
  parameter int FREE_DEPTH = grp_pkg::FREE_DEPTH_DEF,
  parameter int COORD_BITS = grp_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [grp_pkg::IN_DATA_BITS-1:0]  in_tdata,  // img_width, img_height
  input  logic                              in_tuser,  // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [grp_pkg::OUT_DATA_BITS-1:0] out_tdata, // place_x, place_y, sheet_w, sheet_h
  output logic [1:0]                        out_tuser  // status
);
  import grp_pkg::*;

  grp_cmd_t cmd;
  grp_sts_t sts;

  grp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  grp_dpath #(
    .MAX_IMAGES (MAX_IMAGES),
    .FREE_DEPTH (FREE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/grp_ram.sv =====
// ----------------------------------------------------------------------------
// grp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module grp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/grp_dpath.sv =====
// ----------------------------------------------------------------------------
// grp_dpath
// Free-region list, scan pipeline, region split and result register.
// ----------------------------------------------------------------------------
module grp_dpath #(
  parameter int MAX_IMAGES = 256,
  parameter int FREE_DEPTH = 512,
  parameter int COORD_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  grp_pkg::grp_cmd_t                  cmd,
  output grp_pkg::grp_sts_t                  sts,
  input  logic [grp_pkg::IN_DATA_BITS-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [grp_pkg::OUT_DATA_BITS-1:0]  out_tdata,
  output logic [1:0]                         out_tuser
);
  import grp_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int PW  = 2 * CB;
  localparam int EW  = 4 * CB;
  localparam int AW  = $clog2(FREE_DEPTH);
  localparam int FW  = $clog2(FREE_DEPTH + 1);
  localparam int PTW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES + 1) : 1;

  // item and sheet
  logic [IMG_BITS-1:0] w_r, h_r;
  logic [CB-1:0]       cur_w_r, cur_h_r;
  logic [PW-1:0]       cur_area_r;
  logic [FW-1:0]       free_total_r;
  logic [PTW-1:0]      placed_r;

  // scan issue
  logic          scanning_r, scan_sq_r, gap_r;
  logic [FW-1:0] scan_cnt_r;
  logic          issue;

  // pipeline
  logic          rv_r;
  logic [AW-1:0] ridx_r;
  logic          s1_v_r, s1_fit_r;
  logic [CB-1:0] s1_nw_r, s1_nh_r;
  logic [AW-1:0] s1_idx_r;
  logic          s2_v_r, s2_fit_r;
  logic [PW-1:0] s2_a_r, s2_b_r;
  logic [CB-1:0] s2_mn_r, s2_mx_r;
  logic [AW-1:0] s2_idx_r;

  // running best
  logic          found_r;
  logic [PW-1:0] best_val_r;
  logic [CB-1:0] bmn_r, bmx_r;
  logic [AW-1:0] best_idx_r;

  // chosen and last entries
  logic [EW-1:0] sel_r, last_r;

  // result register
  logic                out_v_r;
  status_t             out_st_r;
  logic [OUT_BITS-1:0] out_x_r, out_y_r, out_w_r, out_h_r;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  grp_ram #(.WIDTH(EW), .DEPTH(FREE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic [CB-1:0] wc, hc;
  assign wc = CB'(w_r);
  assign hc = CB'(h_r);

  // scan: one word per cycle for area, a slower, gapped issue for squareness
  assign issue = scanning_r && (!scan_sq_r || !gap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      scan_sq_r  <= 1'b0;
      gap_r      <= 1'b0;
      scan_cnt_r <= '0;
    end else if (cmd.scan_go) begin
      scanning_r <= 1'b1;
      scan_sq_r  <= cmd.scan_sq;
      gap_r      <= 1'b0;
      scan_cnt_r <= '0;
    end else if (scanning_r) begin
      if (scan_sq_r) begin
        gap_r <= ~gap_r;
      end
      if (issue) begin
        scan_cnt_r <= scan_cnt_r + FW'(1);
        if (scan_cnt_r == free_total_r - FW'(1)) begin
          scanning_r <= 1'b0;
        end
      end
    end
  end

  // stage 1: fit test and grown sheet size
  logic [CB-1:0] rx, ry, rw, rh, ex_w, ex_h;
  assign rx = ram_rdata[CB-1:0];
  assign ry = ram_rdata[2*CB-1:CB];
  assign rw = ram_rdata[3*CB-1:2*CB];
  assign rh = ram_rdata[4*CB-1:3*CB];
  assign ex_w = rx + wc;
  assign ex_h = ry + hc;

  // stage 2: products
  logic [CB-1:0] mn, mx, mx_fix, opa, opb;
  assign mn     = (s1_nw_r < s1_nh_r) ? s1_nw_r : s1_nh_r;
  assign mx     = (s1_nw_r < s1_nh_r) ? s1_nh_r : s1_nw_r;
  assign mx_fix = (mx == '0) ? CB'(1) : mx;
  assign opa    = scan_sq_r ? mn : s1_nw_r;
  assign opb    = scan_sq_r ? bmx_r : s1_nh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r   <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      rv_r   <= issue;
      s1_v_r <= rv_r;
      s2_v_r <= s1_v_r;
    end
    ridx_r   <= scan_cnt_r[AW-1:0];
    s1_fit_r <= (rw >= wc) && (rh >= hc);
    s1_nw_r  <= (ex_w > cur_w_r) ? ex_w : cur_w_r;
    s1_nh_r  <= (ex_h > cur_h_r) ? ex_h : cur_h_r;
    s1_idx_r <= ridx_r;
    s2_fit_r <= s1_fit_r;
    s2_a_r   <= PW'(opa) * PW'(opb);
    s2_b_r   <= PW'(bmn_r) * PW'(mx_fix);
    s2_mn_r  <= mn;
    s2_mx_r  <= mx_fix;
    s2_idx_r <= s1_idx_r;
  end

  // stage 3: keep the first best
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.scan_go) begin
      found_r <= 1'b0;
    end else if (s2_v_r && s2_fit_r) begin
      if (!scan_sq_r) begin
        if (!found_r || s2_a_r < best_val_r) begin
          found_r    <= 1'b1;
          best_val_r <= s2_a_r;
          best_idx_r <= s2_idx_r;
        end
      end else if (!found_r || s2_a_r > s2_b_r) begin
        found_r    <= 1'b1;
        bmn_r      <= s2_mn_r;
        bmx_r      <= s2_mx_r;
        best_idx_r <= s2_idx_r;
      end
    end
  end

  // split of the chosen region
  logic [CB-1:0] sx, sy, sw, sh, nx, ny;
  logic          keep_right, keep_bottom, move_last;
  logic [FW-1:0] cnt;
  assign sx = sel_r[CB-1:0];
  assign sy = sel_r[2*CB-1:CB];
  assign sw = sel_r[3*CB-1:2*CB];
  assign sh = sel_r[4*CB-1:3*CB];
  assign nx = sx + wc;
  assign ny = sy + hc;
  assign keep_right  = (sw != wc) && (h_r != '0);
  assign keep_bottom = (sw != '0) && (sh != hc);
  assign move_last   = !keep_right && (FW'(best_idx_r) + FW'(1) < free_total_r);
  assign cnt         = keep_right ? free_total_r : free_total_r - FW'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    ram_wdata = last_r;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = {{PW{1'b1}}, {PW{1'b0}}};
    end else if (cmd.wr_best) begin
      ram_we = keep_right || move_last;
      if (keep_right) begin
        ram_wdata = {hc, sw - wc, sy, nx};
      end
    end else if (cmd.wr_bottom) begin
      ram_we    = keep_bottom;
      ram_waddr = cnt[AW-1:0];
      ram_wdata = {sh - hc, sw, ny, sx};
    end
  end

  always_comb begin
    ram_re    = issue || cmd.rd_best || cmd.rd_last;
    ram_raddr = scan_cnt_r[AW-1:0];
    if (cmd.rd_best) begin
      ram_raddr = best_idx_r;
    end else if (cmd.rd_last) begin
      ram_raddr = AW'(free_total_r - FW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_best) begin
      sel_r <= ram_rdata;
    end
    if (cmd.cap_last) begin
      last_r <= ram_rdata;
    end
    if (cmd.load) begin
      w_r        <= in_tdata[IMG_BITS-1:0];
      h_r        <= in_tdata[2*IMG_BITS-1:IMG_BITS];
      cur_area_r <= PW'(cur_w_r) * PW'(cur_h_r);
    end
  end

  // sheet state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      free_total_r <= FW'(1);
      placed_r     <= '0;
      cur_w_r      <= '0;
      cur_h_r      <= '0;
    end else if (cmd.commit) begin
      free_total_r <= cnt + FW'(keep_bottom);
      placed_r     <= placed_r + PTW'(1);
      cur_w_r      <= (nx > cur_w_r) ? nx : cur_w_r;
      cur_h_r      <= (ny > cur_h_r) ? ny : cur_h_r;
    end
  end

  // result register
  assign sts.out_free = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load && sts.out_free) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (cmd.out_load && sts.out_free) begin
      out_st_r <= cmd.out_status;
      out_x_r  <= (cmd.out_status == ST_PLACED) ? OUT_BITS'(sx) : '0;
      out_y_r  <= (cmd.out_status == ST_PLACED) ? OUT_BITS'(sy) : '0;
      out_w_r  <= OUT_BITS'(cur_w_r);
      out_h_r  <= OUT_BITS'(cur_h_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {out_h_r, out_w_r, out_y_r, out_x_r};

  assign sts.placed_full = placed_r >= PTW'(MAX_IMAGES);
  assign sts.list_empty  = free_total_r == '0;
  assign sts.scan_busy   = scanning_r || rv_r || s1_v_r || s2_v_r;
  assign sts.found       = found_r;
  assign sts.best_zero   = best_val_r == cur_area_r;
  assign sts.cap_fail    = keep_bottom && (cnt == FW'(FREE_DEPTH));

endmodule

// ===== rtl/grp_ctrl.sv =====
// ----------------------------------------------------------------------------
// grp_ctrl
// Sequencer: accept a word, run the scans, split the region, hand off result.
// ----------------------------------------------------------------------------
module grp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_kind,
  output logic              in_tready,
  output grp_pkg::grp_cmd_t cmd,
  input  grp_pkg::grp_sts_t sts
);
  import grp_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLR, S_CHECK, S_SCAN1, S_WAIT1, S_SCAN2, S_WAIT2,
    S_RDB, S_CAPB, S_CAPL, S_SPLIT, S_WBOT, S_COMMIT, S_DONE
  } state_t;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_INIT;
      status_r <= ST_CLEARED;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.out_status = status_r;
    unique case (state_r)
      S_INIT: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = in_kind ? S_CHECK : S_CLR;
        end
      end
      S_CLR: begin
        cmd.clear  = 1'b1;
        status_nxt = ST_CLEARED;
        state_nxt  = S_DONE;
      end
      S_CHECK: begin
        if (sts.placed_full || sts.list_empty) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SCAN1;
        end
      end
      S_SCAN1: begin
        cmd.scan_go = 1'b1;
        state_nxt   = S_WAIT1;
      end
      S_WAIT1: begin
        if (!sts.scan_busy) begin
          if (!sts.found) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = sts.best_zero ? S_RDB : S_SCAN2;
          end
        end
      end
      S_SCAN2: begin
        cmd.scan_go = 1'b1;
        cmd.scan_sq = 1'b1;
        state_nxt   = S_WAIT2;
      end
      S_WAIT2: begin
        if (!sts.scan_busy) begin
          state_nxt = S_RDB;
        end
      end
      S_RDB: begin
        cmd.rd_best = 1'b1;
        state_nxt   = S_CAPB;
      end
      S_CAPB: begin
        cmd.cap_best = 1'b1;
        cmd.rd_last  = 1'b1;
        state_nxt    = S_CAPL;
      end
      S_CAPL: begin
        cmd.cap_last = 1'b1;
        state_nxt    = S_SPLIT;
      end
      S_SPLIT: begin
        if (sts.cap_fail) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_best = 1'b1;
          state_nxt   = S_WBOT;
        end
      end
      S_WBOT: begin
        cmd.wr_bottom = 1'b1;
        state_nxt     = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        status_nxt = ST_PLACED;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        // hold until the result register can take the word
        cmd.out_load = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/grp_checker.sv =====
// ----------------------------------------------------------------------------
// grp_checker
// Port-level checks on the result channel of the packer.
// ----------------------------------------------------------------------------
`include "guillotine_rect_packer_unit_assert.svh"

module grp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [grp_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic [1:0]                        out_tuser
);
  import grp_pkg::*;

  `GRP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result word changed")
  `GRP_ASSERT_IMP(a_clear_zero, out_tvalid && out_tuser == ST_CLEARED, out_tdata == '0, "start word must report an empty sheet")
  `GRP_ASSERT_IMP(a_full_noplace, out_tvalid && out_tuser == ST_FULL, out_tdata[2*OUT_BITS-1:0] == '0, "rejected word must carry no position")
  `GRP_ASSERT_IMP(a_in_sheet, out_tvalid && out_tuser == ST_PLACED, (out_tdata[3*OUT_BITS-1:2*OUT_BITS] >= out_tdata[OUT_BITS-1:0]) && (out_tdata[4*OUT_BITS-1:3*OUT_BITS] >= out_tdata[2*OUT_BITS-1:OUT_BITS]), "placed image lies outside the sheet")

endmodule

bind guillotine_rect_packer_unit grp_checker u_grp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/guillotine_rect_packer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_packer_unit_tb
// Drives start and place words into the packer with random idle bursts on
// both stream sides, and tracks the sheet and its free-region list
// alongside the block. Every result word is checked field by field against
// the oldest pending expectation: a short directed table first, then random
// runs of places, including one run long enough to hit the image limit.
// ----------------------------------------------------------------------------
module guillotine_rect_packer_unit_tb;
  import grp_pkg::*;

  localparam int NREG  = FREE_DEPTH_DEF;
  localparam int NIMG  = MAX_IMAGES_DEF;
  localparam logic [19:0] CFULL = 20'hFFFFF;

  typedef struct packed {
    status_t     st;
    logic [19:0] px;
    logic [19:0] py;
    logic [19:0] sw;
    logic [19:0] sh;
  } sheet_word_t;

  typedef struct {
    bit          kind;
    int unsigned w;
    int unsigned h;
    bit          typed;
    sheet_word_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic [1:0] out_tuser;

  // shadow of the sheet and its free regions
  logic [19:0] reg_x [NREG];
  logic [19:0] reg_y [NREG];
  logic [19:0] reg_w [NREG];
  logic [19:0] reg_h [NREG];
  int unsigned regions_live;
  int unsigned images_placed;
  longint unsigned sheet_w, sheet_h;

  sheet_word_t pending_words[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  int sent = 0;

  guillotine_rect_packer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #6 clk = ~clk;

  function automatic void clear_sheet();
    for (int i = 0; i < NREG; i++) begin
      reg_x[i] = '0; reg_y[i] = '0; reg_w[i] = '0; reg_h[i] = '0;
    end
    reg_w[0] = CFULL;
    reg_h[0] = CFULL;
    regions_live = 1;
    images_placed = 0;
    sheet_w = 0;
    sheet_h = 0;
  endfunction

  function automatic sheet_word_t pack_image(bit kind, int unsigned w, int unsigned h);
    sheet_word_t r;
    int unsigned n, best, cnt;
    bit found, keep_right, keep_bottom;
    longint unsigned area, inc, best_inc, bmn, bmx, nw, nh, mn, mx, rx, ry, rw, rh;
    n = (regions_live > NREG) ? NREG : regions_live;
    area = sheet_w * sheet_h;
    best_inc = 0; bmn = 0; bmx = 1; best = 0; found = 1'b0;
    r = '{st: ST_FULL, px: '0, py: '0, sw: '0, sh: '0};
    if (!kind) begin
      clear_sheet();
      r.st = ST_CLEARED;
      return r;
    end
    r.sw = sheet_w[19:0];
    r.sh = sheet_h[19:0];
    if (images_placed >= NIMG) return r;
    // smallest area growth, first wins ties
    for (int i = 0; i < n; i++) begin
      if (reg_w[i] >= w && reg_h[i] >= h) begin
        nw = (reg_x[i] + w > sheet_w) ? reg_x[i] + w : sheet_w;
        nh = (reg_y[i] + h > sheet_h) ? reg_y[i] + h : sheet_h;
        inc = nw * nh - area;
        if (!found || inc < best_inc) begin
          found = 1'b1; best_inc = inc; best = i;
        end
      end
    end
    if (!found) return r;
    // every choice grows the sheet: go for the squarest one
    if (best_inc > 0) begin
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (reg_w[i] >= w && reg_h[i] >= h) begin
          nw = (reg_x[i] + w > sheet_w) ? reg_x[i] + w : sheet_w;
          nh = (reg_y[i] + h > sheet_h) ? reg_y[i] + h : sheet_h;
          mn = (nw < nh) ? nw : nh;
          mx = (nw < nh) ? nh : nw;
          if (mx == 0) mx = 1;
          if (!found || mn * bmx > bmn * mx) begin
            found = 1'b1; bmn = mn; bmx = mx; best = i;
          end
        end
      end
    end
    rx = reg_x[best]; ry = reg_y[best]; rw = reg_w[best]; rh = reg_h[best];
    keep_right = (rw - w) != 0 && h != 0;
    keep_bottom = rw != 0 && (rh - h) != 0;
    cnt = n;
    if (!keep_right) cnt--;
    if (keep_bottom && cnt + 1 > NREG) return r;
    if (keep_right) begin
      reg_x[best] = rx + w; reg_y[best] = ry;
      reg_w[best] = rw - w; reg_h[best] = h;
    end else if (best + 1 < n) begin
      // last live region fills the hole
      reg_x[best] = reg_x[n-1]; reg_y[best] = reg_y[n-1];
      reg_w[best] = reg_w[n-1]; reg_h[best] = reg_h[n-1];
    end
    if (keep_bottom) begin
      reg_x[cnt] = rx; reg_y[cnt] = ry + h;
      reg_w[cnt] = rw; reg_h[cnt] = rh - h;
      cnt++;
    end
    regions_live = cnt;
    images_placed++;
    if (rx + w > sheet_w) sheet_w = rx + w;
    if (ry + h > sheet_h) sheet_h = ry + h;
    r = '{st: ST_PLACED, px: rx[19:0], py: ry[19:0], sw: sheet_w[19:0], sh: sheet_h[19:0]};
    return r;
  endfunction

  // send one word; inputs move only at the falling edge
  task automatic send_word(bit kind, int unsigned w, int unsigned h, bit typed,
                           sheet_word_t typed_res);
    sheet_word_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {h[11:0], w[11:0]};
    do @(posedge clk); while (!in_tready);
    pred = pack_image(kind, w, h);
    pending_words.push_back(typed ? typed_res : pred);
    sent++;
  endtask

  task automatic send_pred(bit kind, int unsigned w, int unsigned h);
    send_word(kind, w, h, 1'b0, '0);
  endtask

  function automatic int unsigned rand_side();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 4095);
      1: return 0;
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  // result side: random stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sheet_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{st: status_t'(out_tuser), px: out_tdata[19:0], py: out_tdata[39:20],
              sw: out_tdata[59:40], sh: out_tdata[79:60]};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_words.pop_front();
        if (got.st !== want.st || got.px !== want.px || got.py !== want.py ||
            got.sw !== want.sw || got.sh !== want.sh) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d x=%0d y=%0d w=%0d h=%0d, got st=%0d x=%0d y=%0d w=%0d h=%0d",
                     want.st, want.px, want.py, want.sw, want.sh,
                     got.st, got.px, got.py, got.sw, got.sh);
        end
      end
    end
  end

  initial begin
    #(12 * 8000000);
    $display("guillotine_rect_packer_unit_tb failed");
    $finish;
  end

  initial begin
    dir_row_t table_rows[$];
    int unsigned len;
    bit long_done;
    clear_sheet();
    table_rows = '{
      '{0, 0, 0, 1, '{ST_CLEARED, 0, 0, 0, 0}},
      '{1, 4095, 4095, 1, '{ST_PLACED, 0, 0, 4095, 4095}},
      '{0, 4095, 4095, 1, '{ST_CLEARED, 0, 0, 0, 0}},
      '{1, 1, 1, 1, '{ST_PLACED, 0, 0, 1, 1}},
      '{1, 0, 5, 0, '0},
      '{1, 7, 0, 0, '0},
      '{1, 0, 0, 0, '0},
      '{1, 4095, 1, 0, '0},
      '{1, 1, 4095, 0, '0},
      '{1, 2048, 2048, 0, '0},
      '{1, 12'hAAA, 12'h555, 0, '0},
      '{1, 12'h555, 12'hAAA, 0, '0},
      '{1, 3, 3, 0, '0},
      '{1, 4095, 4095, 0, '0},
      '{0, 12'h555, 12'hAAA, 1, '{ST_CLEARED, 0, 0, 0, 0}},
      '{1, 10, 20, 0, '0},
      '{1, 20, 10, 0, '0},
      '{1, 10, 10, 0, '0}
    };
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (table_rows[i])
      send_word(table_rows[i].kind, table_rows[i].w, table_rows[i].h,
                table_rows[i].typed, table_rows[i].res);
    long_done = 1'b0;
    while (sent < 500) begin
      if (sent > 420) quiet = 1'b1;
      // start word with random payload, then a run of places
      send_pred(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095));
      if (!long_done && sent > 60) begin
        len = NIMG + 4;
        long_done = 1'b1;
      end else begin
        len = $urandom_range(1, 30);
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 29) == 0 && len < NIMG)
          send_pred(1'b0, rand_side(), rand_side());
        else
          send_pred(1'b1, rand_side(), rand_side());
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("guillotine_rect_packer_unit_tb passed");
    end else begin
      $display("guillotine_rect_packer_unit_tb failed");
    end
    $finish;
  end

endmodule
